/* design/tpn_pkg.sv */
// shared types and constants for the ticket paxos node
// message codes, payload structs and config register indexes; no dependencies
package tpn_pkg;

  localparam int unsigned TICKET_W  = 8;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned VOTE_W    = 5;
  localparam int unsigned NCOUNT_W  = 5;
  localparam int unsigned NID_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;

  // message codes, shared by func and out_kind
  localparam logic [FUNC_W-1:0] FN_REQ_TICKET   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REQ_PROPOSE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REQ_COMMIT   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RESP_TICKET  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESP_PROPOSE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESP_COMMIT  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLIENT       = 3'd6;
  // on the result side, code six reports a finished commit
  localparam logic [FUNC_W-1:0] FN_COMMIT_DONE  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'd1;

  localparam logic [CMD_W-1:0]    EMPTY_CMD       = 8'd101;
  localparam logic [CMD_W-1:0]    DIGIT_ZERO      = 8'd48;
  localparam logic [VOTE_W-1:0]   VOTE_MAX        = 5'd31;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST  = 5'd5;
  localparam logic [NID_W-1:0]    NODE_ID_RST     = 4'd0;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [TICKET_W-1:0] msg_ticket;
    logic                msg_ok;
    logic [CMD_W-1:0]    msg_command;
  } tpn_in_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   out_kind;
    logic                out_broadcast;
    logic                out_ok;
    logic [TICKET_W-1:0] out_ticket;
    logic [CMD_W-1:0]    out_command;
  } tpn_out_t;

endpackage

/* design/ticket_paxos_node_step.sv */
// ticket paxos node: acceptor and proposer, one decoded message per item
// depends on tpn_pkg for payload structs, message codes and constants
//
// One item per clock while out_stall does not hold the result register. An
// accepted item is held in an input register; the acceptor and proposer
// state and the result are worked out from it by a single level of compares
// and increments and land in the result register. Acceptor requests always
// give one reply; proposer replies give a result only when the vote
// completes (node_count-2 replies counted); a client request always
// broadcasts a fresh ticket request. Code seven gives nothing. in_stall
// rises only while the input register is full and the result register
// holds an item that out_stall is holding back.
module ticket_paxos_node_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tpn_pkg::tpn_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tpn_pkg::tpn_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [tpn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpn_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import tpn_pkg::*;

  logic                 in_v_r;
  tpn_in_t              item_r;
  logic                 out_v_r;
  tpn_out_t             res_r;

  logic [NCOUNT_W-1:0]  node_count_r;
  logic [NID_W-1:0]     node_id_r;
  logic [TICKET_W-1:0]  highest_r, highest_nxt;
  logic [CMD_W-1:0]     acc_cmd_r, acc_cmd_nxt;
  logic [TICKET_W-1:0]  stored_r, stored_nxt;
  logic                 committed_r, committed_nxt;
  logic [TICKET_W-1:0]  own_ticket_r, own_ticket_nxt;
  logic [CMD_W-1:0]     own_prop_r, own_prop_nxt;
  logic [VOTE_W-1:0]    yes_r, yes_nxt;
  logic [VOTE_W-1:0]    no_r, no_nxt;

  logic                 fire;
  logic                 has_res;
  tpn_out_t             res;

  logic [VOTE_W-1:0]    yes_cnt, no_cnt;
  logic [VOTE_W:0]      vote_sum;
  logic [NCOUNT_W-1:0]  need;
  logic                 vote_done;
  logic                 vote_won;
  logic [TICKET_W-1:0]  next_ticket;
  logic [CMD_W-1:0]     new_prop;

  // the staged item moves on when the result register is free or draining
  assign fire      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && out_v_r && out_stall;
  assign out_valid = out_v_r;
  assign out_data  = res_r;

  // vote counting, counters saturate
  always_comb begin
    yes_cnt = yes_r;
    no_cnt  = no_r;
    if (item_r.msg_ok) begin
      if (yes_r < VOTE_MAX) yes_cnt = yes_r + 1'b1;
    end else begin
      if (no_r < VOTE_MAX) no_cnt = no_r + 1'b1;
    end
    vote_sum  = {1'b0, yes_cnt} + {1'b0, no_cnt};
    need      = node_count_r - NCOUNT_W'(2);
    vote_done = (node_count_r >= NCOUNT_W'(3)) && (vote_sum == {1'b0, need});
    vote_won  = yes_cnt >= (node_count_r >> 1);
  end

  assign next_ticket = own_ticket_r + 1'b1;
  assign new_prop    = (item_r.msg_command != EMPTY_CMD) ? item_r.msg_command : own_prop_r;

  always_comb begin
    highest_nxt    = highest_r;
    acc_cmd_nxt    = acc_cmd_r;
    stored_nxt     = stored_r;
    committed_nxt  = committed_r;
    own_ticket_nxt = own_ticket_r;
    own_prop_nxt   = own_prop_r;
    yes_nxt        = yes_r;
    no_nxt         = no_r;
    has_res        = 1'b0;
    res            = '0;
    case (item_r.func)
      FN_REQ_TICKET: begin
        has_res      = 1'b1;
        res.out_kind = FN_RESP_TICKET;
        if (item_r.msg_ticket > highest_r) begin
          highest_nxt     = item_r.msg_ticket;
          res.out_ok      = 1'b1;
          res.out_command = acc_cmd_r;
        end
      end
      FN_REQ_PROPOSE: begin
        has_res      = 1'b1;
        res.out_kind = FN_RESP_PROPOSE;
        if (item_r.msg_ticket == highest_r) begin
          acc_cmd_nxt = item_r.msg_command;
          stored_nxt  = item_r.msg_ticket;
          res.out_ok  = 1'b1;
        end
      end
      FN_REQ_COMMIT: begin
        has_res      = 1'b1;
        res.out_kind = FN_RESP_COMMIT;
        if (item_r.msg_ticket == stored_r && item_r.msg_command == acc_cmd_r) begin
          committed_nxt = 1'b1;
          res.out_ok    = 1'b1;
        end
      end
      FN_RESP_TICKET, FN_RESP_PROPOSE, FN_RESP_COMMIT: begin
        yes_nxt = yes_cnt;
        no_nxt  = no_cnt;
        if (vote_done) begin
          yes_nxt = '0;
          no_nxt  = '0;
          has_res = 1'b1;
          if (!vote_won) begin
            own_ticket_nxt    = next_ticket;
            res.out_kind      = FN_REQ_TICKET;
            res.out_broadcast = 1'b1;
            res.out_ticket    = next_ticket;
          end else if (item_r.func == FN_RESP_TICKET) begin
            own_prop_nxt      = new_prop;
            res.out_kind      = FN_REQ_PROPOSE;
            res.out_broadcast = 1'b1;
            res.out_ticket    = own_ticket_r;
            res.out_command   = new_prop;
          end else if (item_r.func == FN_RESP_PROPOSE) begin
            res.out_kind      = FN_REQ_COMMIT;
            res.out_broadcast = 1'b1;
            res.out_ticket    = own_ticket_r;
            res.out_command   = own_prop_r;
          end else begin
            res.out_kind = FN_COMMIT_DONE;
            res.out_ok   = 1'b1;
          end
        end
      end
      FN_CLIENT: begin
        own_ticket_nxt    = next_ticket;
        has_res           = 1'b1;
        res.out_kind      = FN_REQ_TICKET;
        res.out_broadcast = 1'b1;
        res.out_ticket    = next_ticket;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= (in_valid && !in_stall) || (in_v_r && !fire);
    end
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= has_res;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
    if (fire && has_res) begin
      res_r <= res;
    end
  end

  // node state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      node_id_r    <= NODE_ID_RST;
      highest_r    <= '0;
      acc_cmd_r    <= EMPTY_CMD;
      stored_r     <= '0;
      committed_r  <= 1'b0;
      own_ticket_r <= '0;
      own_prop_r   <= DIGIT_ZERO + CMD_W'(NODE_ID_RST);
      yes_r        <= '0;
      no_r         <= '0;
    end else if (fire) begin
      highest_r    <= highest_nxt;
      acc_cmd_r    <= acc_cmd_nxt;
      stored_r     <= stored_nxt;
      committed_r  <= committed_nxt;
      own_ticket_r <= own_ticket_nxt;
      own_prop_r   <= own_prop_nxt;
      yes_r        <= yes_nxt;
      no_r         <= no_nxt;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: begin
          node_count_r <= cfg_wdata[NCOUNT_W-1:0];
        end
        CFG_NODE_ID: begin
          node_id_r  <= cfg_wdata[NID_W-1:0];
          // the node's own digit character becomes its proposal
          own_prop_r <= DIGIT_ZERO + CMD_W'(cfg_wdata[NID_W-1:0]);
        end
        default: begin
          node_count_r <= node_count_r;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with empty input register");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(in_v_r))
    else $error("result appeared without a staged item");

  a_highest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> highest_r >= $past(highest_r))
    else $error("highest ticket went down");

  a_commit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(committed_r))
    else $error("committed flag cleared");

  a_node_id_proposal: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && !fire && cfg_index == CFG_NODE_ID) |=>
      own_prop_r == DIGIT_ZERO + CMD_W'(node_id_r))
    else $error("node id write did not reload the proposal");
`endif

endmodule

/* sim/ticket_paxos_node_step_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for ticket_paxos_node_step: directed messages, then random ones
// over nine node settings; depends on tpn_pkg and the ticket_paxos_node_step rtl
module ticket_paxos_node_step_test;
  import tpn_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 195;
  localparam int NUM_PHASES     = 9;
  localparam int REPORT_LIMIT   = 10;
  // node count two stays last: its vote counters saturate and never clear again
  localparam int PHASE_NODES[NUM_PHASES] = '{3, 16, 5, 16, 3, 8, 4, 11, 2};
  localparam int PHASE_IDS[NUM_PHASES]   = '{0, 15, 9, 4, 12, 1, 7, 3, 6};

  typedef enum {VOTE_OPEN, VOTE_WON, VOTE_LOST} vote_t;

  // tracks acceptor and proposer state and holds the replies still owed
  class paxos_reply_tracker;
    logic [NCOUNT_W-1:0] node_count;
    logic [NID_W-1:0]    node_id;
    logic [TICKET_W-1:0] highest_ticket;
    logic [TICKET_W-1:0] stored_ticket;
    logic [TICKET_W-1:0] own_ticket;
    logic [CMD_W-1:0]    accepted_command;
    logic [CMD_W-1:0]    own_proposal;
    logic                committed;
    logic [VOTE_W-1:0]   yes_votes;
    logic [VOTE_W-1:0]   no_votes;
    tpn_out_t            pending_replies[$];
    int unsigned         replies_seen;
    int unsigned         errors;

    function new();
      node_count       = NODE_COUNT_RST;
      node_id          = NODE_ID_RST;
      highest_ticket   = '0;
      stored_ticket    = '0;
      own_ticket       = '0;
      accepted_command = EMPTY_CMD;
      own_proposal     = DIGIT_ZERO + CMD_W'(NODE_ID_RST);
      committed        = 1'b0;
      yes_votes        = '0;
      no_votes         = '0;
      replies_seen     = 0;
      errors           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
      if (idx == CFG_NODE_COUNT) begin
        node_count = value[NCOUNT_W-1:0];
      end else begin
        node_id      = value[NID_W-1:0];
        own_proposal = DIGIT_ZERO + CMD_W'(node_id);
      end
    endfunction

    function int votes_cast();
      return int'(yes_votes) + int'(no_votes);
    endfunction

    function void queue_reply(logic [FUNC_W-1:0] kind, logic bc, logic ok,
                              logic [TICKET_W-1:0] ticket, logic [CMD_W-1:0] cmd);
      tpn_out_t r;
      r.out_kind      = kind;
      r.out_broadcast = bc;
      r.out_ok        = ok;
      r.out_ticket    = ticket;
      r.out_command   = cmd;
      pending_replies.push_back(r);
    endfunction

    function void restart_ballot();
      own_ticket = own_ticket + 1'b1;
      queue_reply(FN_REQ_TICKET, 1'b1, 1'b0, own_ticket, '0);
    endfunction

    function vote_t count_vote(logic ok);
      logic won;
      if (ok) begin
        if (yes_votes < VOTE_MAX) yes_votes = yes_votes + 1'b1;
      end else begin
        if (no_votes < VOTE_MAX) no_votes = no_votes + 1'b1;
      end
      if (node_count < 3 || votes_cast() != int'(node_count) - 2) return VOTE_OPEN;
      won       = (yes_votes >= node_count / 2);
      yes_votes = '0;
      no_votes  = '0;
      return won ? VOTE_WON : VOTE_LOST;
    endfunction

    function void take_message(tpn_in_t m);
      vote_t v;
      case (m.func)
        FN_REQ_TICKET: begin
          if (m.msg_ticket > highest_ticket) begin
            highest_ticket = m.msg_ticket;
            queue_reply(FN_RESP_TICKET, 1'b0, 1'b1, '0, accepted_command);
          end else begin
            queue_reply(FN_RESP_TICKET, 1'b0, 1'b0, '0, '0);
          end
        end
        FN_REQ_PROPOSE: begin
          if (m.msg_ticket == highest_ticket) begin
            accepted_command = m.msg_command;
            stored_ticket    = m.msg_ticket;
            queue_reply(FN_RESP_PROPOSE, 1'b0, 1'b1, '0, '0);
          end else begin
            queue_reply(FN_RESP_PROPOSE, 1'b0, 1'b0, '0, '0);
          end
        end
        FN_REQ_COMMIT: begin
          if (m.msg_ticket == stored_ticket && m.msg_command == accepted_command) begin
            committed = 1'b1;
            queue_reply(FN_RESP_COMMIT, 1'b0, 1'b1, '0, '0);
          end else begin
            queue_reply(FN_RESP_COMMIT, 1'b0, 1'b0, '0, '0);
          end
        end
        FN_RESP_TICKET, FN_RESP_PROPOSE, FN_RESP_COMMIT: begin
          v = count_vote(m.msg_ok);
          if (v == VOTE_LOST) begin
            restart_ballot();
          end else if (v == VOTE_WON) begin
            case (m.func)
              FN_RESP_TICKET: begin
                // an empty command in the deciding reply keeps our own proposal
                if (m.msg_command != EMPTY_CMD) own_proposal = m.msg_command;
                queue_reply(FN_REQ_PROPOSE, 1'b1, 1'b0, own_ticket, own_proposal);
              end
              FN_RESP_PROPOSE: begin
                queue_reply(FN_REQ_COMMIT, 1'b1, 1'b0, own_ticket, own_proposal);
              end
              default: begin
                queue_reply(FN_COMMIT_DONE, 1'b0, 1'b1, '0, '0);
              end
            endcase
          end
        end
        FN_CLIENT: restart_ballot();
        default: ;
      endcase
    endfunction

    function void match_reply(tpn_out_t got);
      tpn_out_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected reply: kind %0d bc %0d ok %0d ticket %0d cmd %0d",
                   got.out_kind, got.out_broadcast, got.out_ok, got.out_ticket,
                   got.out_command);
        return;
      end
      want = pending_replies.pop_front();
      replies_seen++;
      if (got.out_kind !== want.out_kind || got.out_broadcast !== want.out_broadcast ||
          got.out_ok !== want.out_ok || got.out_ticket !== want.out_ticket ||
          got.out_command !== want.out_command) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $write("reply %0d mismatch: exp kind %0d bc %0d ok %0d ticket %0d cmd %0d",
                 replies_seen, want.out_kind, want.out_broadcast, want.out_ok,
                 want.out_ticket, want.out_command);
          $display(", got kind %0d bc %0d ok %0d ticket %0d cmd %0d",
                   got.out_kind, got.out_broadcast, got.out_ok, got.out_ticket,
                   got.out_command);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  tpn_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tpn_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

  paxos_reply_tracker tracker;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  ticket_paxos_node_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_reply(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d replies outstanding",
               quiet_cycles, tracker.pending_replies.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic tpn_in_t build_msg(logic [FUNC_W-1:0] func, logic [TICKET_W-1:0] ticket,
                                        logic ok, logic [CMD_W-1:0] cmd);
    tpn_in_t m;
    m.func        = func;
    m.msg_ticket  = ticket;
    m.msg_ok      = ok;
    m.msg_command = cmd;
    return m;
  endfunction

  function automatic tpn_in_t vote_message();
    tpn_in_t m;
    m = build_msg(FN_RESP_COMMIT, 8'($urandom), 1'($urandom), 8'($urandom));
    case ($urandom_range(2))
      0: m.func = FN_RESP_TICKET;
      1: m.func = FN_RESP_PROPOSE;
      default: ;
    endcase
    if ($urandom_range(3) == 0) m.msg_command = EMPTY_CMD;
    return m;
  endfunction

  // acceptor requests built from the tracked state, plus vote replies, client requests and noise
  function automatic tpn_in_t random_message();
    tpn_in_t m;
    int pick;
    int top;
    int stride;
    m    = build_msg(FN_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    top  = int'(tracker.highest_ticket);
    if (pick < 14) begin
      m.func = FN_REQ_TICKET;
      if ($urandom_range(1) == 0 && top < 255) begin
        stride       = (255 - top < 3) ? 255 - top : 3;
        m.msg_ticket = 8'(top + $urandom_range(1, stride));
      end else if ($urandom_range(39) != 0) begin
        // keep refusals mostly below the maximum so grants last the whole run
        m.msg_ticket = 8'($urandom_range(0, top));
      end
    end else if (pick < 28) begin
      m.func = FN_REQ_PROPOSE;
      if ($urandom_range(9) < 7) m.msg_ticket = tracker.highest_ticket;
      if ($urandom_range(4) == 0) m.msg_command = EMPTY_CMD;
    end else if (pick < 40) begin
      m.func = FN_REQ_COMMIT;
      if ($urandom_range(9) < 7) begin
        m.msg_ticket  = tracker.stored_ticket;
        m.msg_command = tracker.accepted_command;
      end else if ($urandom_range(1) == 0) begin
        m.msg_ticket = tracker.stored_ticket;
      end
    end else if (pick < 88) begin
      m = vote_message();
    end else if (pick < 96) begin
      m.func = FN_CLIENT;
    end
    return m;
  endfunction

  // starts and ends at a falling edge
  task automatic send_item(input tpn_in_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (in_stall);
    tracker.take_message(m);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(negedge clk);
    // items with no reply may still be in the pipe
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, value);
    @(negedge clk);
  endtask

  initial begin
    int done;
    logic [CFG_DAT_W-1:0] id_word;
    tpn_in_t m;
    tracker = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 6;
    recv_stall_pct = 53;
    // acceptor: refused and granted tickets, proposals and commits
    send_item(build_msg(FN_REQ_TICKET, 8'd0, 1'b0, 8'd0));
    send_item(build_msg(FN_REQ_TICKET, 8'd1, 1'b1, 8'd255));
    send_item(build_msg(FN_REQ_PROPOSE, 8'd255, 1'b0, 8'd0));
    send_item(build_msg(FN_REQ_PROPOSE, 8'd1, 1'b0, 8'd0));
    send_item(build_msg(FN_REQ_TICKET, 8'd2, 1'b0, 8'd0));
    send_item(build_msg(FN_REQ_COMMIT, 8'd1, 1'b0, 8'd0));
    send_item(build_msg(FN_REQ_COMMIT, 8'd1, 1'b1, 8'd5));
    send_item(build_msg(FN_CLIENT, 8'd0, 1'b0, 8'd0));
    // proposer: won ticket vote with empty command, propose, commit report
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b1, EMPTY_CMD));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b1, EMPTY_CMD));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b0, EMPTY_CMD));
    send_item(build_msg(FN_RESP_PROPOSE, 8'd0, 1'b1, 8'd0));
    send_item(build_msg(FN_RESP_PROPOSE, 8'd0, 1'b1, 8'd0));
    send_item(build_msg(FN_RESP_PROPOSE, 8'd0, 1'b0, 8'd0));
    send_item(build_msg(FN_RESP_COMMIT, 8'd0, 1'b1, 8'd0));
    send_item(build_msg(FN_RESP_COMMIT, 8'd0, 1'b0, 8'd0));
    send_item(build_msg(FN_RESP_COMMIT, 8'd0, 1'b1, 8'd0));
    // lost vote starts over, then a won vote takes the carried command
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b0, 8'd200));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b0, 8'd200));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b1, 8'd200));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b1, 8'd200));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b1, 8'd200));
    send_item(build_msg(FN_RESP_TICKET, 8'd0, 1'b1, 8'd200));
    send_item(build_msg(FN_UNUSED, 8'd255, 1'b1, 8'd255));
    send_item(build_msg(FN_REQ_PROPOSE, 8'd2, 1'b1, 8'd255));

    for (int p = 0; p < NUM_PHASES; p++) begin
      // finish the open vote so a smaller node count can still complete
      if (tracker.node_count >= 3) begin
        while (tracker.votes_cast() != 0) send_item(vote_message());
      end
      settle();
      id_word = CFG_DAT_W'(PHASE_IDS[p]);
      if (p % 2 == 1) id_word[CFG_DAT_W-1] = 1'b1;  // top data bit is unused by node_id
      cfg_write(CFG_NODE_COUNT, CFG_DAT_W'(PHASE_NODES[p]));
      cfg_write(CFG_NODE_ID, id_word);
      case (p / 3)
        0: begin send_idle_pct = 6;  recv_stall_pct = 53; end
        1: begin send_idle_pct = 53; recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        m = random_message();
        send_item(m);
        if (m.func != FN_UNUSED) done++;
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    tracker.errors += tracker.pending_replies.size();

    $display("%0d messages sent over %0d node settings (counts 2 to 16, ids 0 to 15)",
             items_sent, NUM_PHASES + 1);
    $display("%0d replies checked, %0d errors", tracker.replies_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
